// ===== hdl/base58_encoder_macros.svh =====
// Assertion macros used by the base58 encoder.
`ifndef BASE58_ENCODER_MACROS_SVH
`define BASE58_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define B58_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("base58 encoder: same-cycle check failed");
`define B58_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base58 encoder: next-cycle check failed");
`else
`define B58_ASSERT_IMP(label, clk, rst, ante, cons)
`define B58_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/b58enc_pkg.sv =====
package b58enc_pkg;

   localparam int MAX_BYTES   = 32;
   localparam int MAX_RESULTS = 45;
   localparam int DIGITS      = MAX_BYTES * 138 / 100 + 1;
   localparam int ADDR_W      = $clog2(DIGITS);
   localparam int USED_W      = $clog2(DIGITS + 1);
   localparam int BCNT_W      = $clog2(MAX_BYTES + 1);
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
   localparam int DIGIT_W     = 6;
   localparam int RADIX       = 58;
   localparam int RECIP       = 18079;
   localparam int RECIP_SHIFT = 20;
   localparam logic [7:0] CHAR_ONE = 8'h31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_SCAN_REQ,
      ST_SCAN_CHK,
      ST_EMIT_ONES,
      ST_EMIT_REQ,
      ST_EMIT_WAIT
   } state_type;

   function automatic logic [7:0] b58_char(input logic [DIGIT_W-1:0] digit);
      logic [7:0] c;
      case (digit) inside
         [6'd0 : 6'd8]   : c = 8'h31 + {2'b00, digit};
         [6'd9 : 6'd16]  : c = 8'h41 + {2'b00, digit - 6'd9};
         [6'd17 : 6'd21] : c = 8'h4A + {2'b00, digit - 6'd17};
         [6'd22 : 6'd32] : c = 8'h50 + {2'b00, digit - 6'd22};
         [6'd33 : 6'd43] : c = 8'h61 + {2'b00, digit - 6'd33};
         [6'd44 : 6'd57] : c = 8'h6D + {2'b00, digit - 6'd44};
         default         : c = CHAR_ONE;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/b58enc_ram.sv =====
module b58enc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 45
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/base58_encoder.sv =====
// Base58 encoder with the Bitcoin alphabet.
// The request channel carries one message byte per transaction, with
// req_last_byte high on the final byte. The response channel carries one
// ASCII character per transaction, leftmost first, with rsp_last_char high
// on the final character and rsp_overflow high if the message was too long.
// Leading zero bytes, and bytes beyond the size limit, are taken in the idle state.
// Any other byte then passes through the absorb state, where the shared
// divide-by-58 unit walks through the digits, at most 45, one digit per cycle.
// After the last byte, the top of the digit memory is scanned down to the
// highest nonzero digit, then each '1' is loaded directly and each further
// character first needs a read of the digit memory.
// Reset empties the message and the response register; no clearing pass is
// needed, as a fill mark shows which digits hold data.
// A stalled receiver holds the character in the output register and pauses
// the emission; the next message may start while the final character waits.
`include "base58_encoder_macros.svh"

module base58_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char,
   output logic       rsp_overflow
);

   import b58enc_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [7:0]        carry_ff, carry_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [BCNT_W-1:0] lz_ff, lz_in;
   logic              in_lz_ff, in_lz_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic              ovf_ff, ovf_in;
   logic              msg_last_ff, msg_last_in;
   logic              has_dig_ff, has_dig_in;
   logic [RCNT_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic               accept, slot_free, load, load_last;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DIGIT_W-1:0] rd_digit, digit_val, rem;
   logic [USED_W-1:0]  ptr_ext, ptr_nx_ext;
   logic [13:0]        sum, rem_wide;
   logic [28:0]        prod;
   logic [7:0]         quot;
   logic               more_digits, at_limit;

   b58enc_ram #(
      .WIDTH(DIGIT_W),
      .DEPTH(DIGITS)
   ) u_digits (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ptr_ff),
      .wr_data(rem),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_digit)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign ptr_ext     = USED_W'(ptr_ff);
   assign ptr_nx_ext  = ptr_ext + 1'b1;
   assign digit_val   = (ptr_ext < used_ff) ? rd_digit : '0;
   assign sum         = {digit_val, carry_ff};
   assign prod        = 29'(sum) * 29'(RECIP);
   assign quot        = prod[RECIP_SHIFT +: 8];
   assign rem_wide    = sum - 14'(quot) * 14'(RADIX);
   assign rem         = rem_wide[DIGIT_W-1:0];
   assign more_digits = (ptr_nx_ext < USED_W'(DIGITS)) &&
                        ((ptr_nx_ext < used_ff) || (quot != 8'd0));
   assign at_limit    = (RCNT_W'(cnt_ff + 1'b1) == RCNT_W'(MAX_RESULTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         lz_ff        <= '0;
         in_lz_ff     <= 1'b1;
         bcnt_ff      <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         lz_ff        <= lz_in;
         in_lz_ff     <= in_lz_in;
         bcnt_ff      <= bcnt_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      carry_ff    <= carry_in;
      msg_last_ff <= msg_last_in;
      has_dig_ff  <= has_dig_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      carry_in    = carry_ff;
      used_in     = used_ff;
      lz_in       = lz_ff;
      in_lz_in    = in_lz_ff;
      bcnt_in     = bcnt_ff;
      ovf_in      = ovf_ff;
      msg_last_in = msg_last_ff;
      has_dig_in  = has_dig_ff;
      cnt_in      = cnt_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff;
      load        = 1'b0;
      load_last   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               msg_last_in = req_last_byte;
               if (bcnt_ff < BCNT_W'(MAX_BYTES)) begin
                  bcnt_in = bcnt_ff + 1'b1;
                  if (in_lz_ff && (req_data_byte == 8'd0)) begin
                     lz_in = lz_ff + 1'b1;
                  end else begin
                     in_lz_in = 1'b0;
                     carry_in = req_data_byte;
                     ptr_in   = '0;
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_ABSORB;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_byte && (state_in == ST_IDLE)) begin
                  if (used_ff == '0) begin
                     has_dig_in = 1'b0;
                     state_in   = ST_EMIT_ONES;
                  end else begin
                     ptr_in   = ADDR_W'(used_ff - 1'b1);
                     state_in = ST_SCAN_REQ;
                  end
               end
            end
         end
         ST_ABSORB: begin
            wr_en    = 1'b1;
            carry_in = quot;
            if (more_digits) begin
               ptr_in  = ADDR_W'(ptr_nx_ext);
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(ptr_nx_ext);
            end else begin
               used_in  = ptr_nx_ext;
               state_in = msg_last_ff ? ST_SCAN_REQ : ST_IDLE;
            end
         end
         ST_SCAN_REQ: begin
            rd_en    = 1'b1;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (rd_digit != '0) begin
               has_dig_in = 1'b1;
               state_in   = (lz_ff != '0) ? ST_EMIT_ONES : ST_EMIT_REQ;
            end else if (ptr_ff == '0) begin
               has_dig_in = 1'b0;
               state_in   = ST_EMIT_ONES;
            end else begin
               ptr_in   = ptr_ff - 1'b1;
               state_in = ST_SCAN_REQ;
            end
         end
         ST_EMIT_ONES: begin
            if (slot_free) begin
               load        = 1'b1;
               load_last   = ((lz_ff == BCNT_W'(1)) && !has_dig_ff) || at_limit;
               rsp_char_in = CHAR_ONE;
               lz_in       = lz_ff - 1'b1;
               if (!load_last && (lz_ff == BCNT_W'(1))) begin
                  state_in = ST_EMIT_REQ;
               end
            end
         end
         ST_EMIT_REQ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (slot_free) begin
               load        = 1'b1;
               load_last   = (ptr_ff == '0) || at_limit;
               rsp_char_in = b58_char(rd_digit);
               if (!load_last) begin
                  ptr_in   = ptr_ff - 1'b1;
                  state_in = ST_EMIT_REQ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         cnt_in      = cnt_ff + 1'b1;
         rsp_last_in = load_last;
         rsp_ovf_in  = ovf_ff;
      end

      if (load && load_last) begin
         used_in  = '0;
         lz_in    = '0;
         in_lz_in = 1'b1;
         bcnt_in  = '0;
         ovf_in   = 1'b0;
         cnt_in   = '0;
         state_in = ST_IDLE;
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   `B58_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= USED_W'(DIGITS))
   `B58_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_ff < RCNT_W'(MAX_RESULTS))
   `B58_ASSERT_IMP(a_emit_in_range, clock, reset, state_ff == ST_EMIT_WAIT, ptr_ext < used_ff)
   `B58_ASSERT_NEXT(a_final_char_idle, clock, reset, load && load_last, state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)
   `B58_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_char_ff))

endmodule

// ===== tb/tb_base58_encoder.sv =====
module tb_base58_encoder;
   import b58enc_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 1500;
   localparam int RANDOM_BYTES = 360;
   localparam int CALM_BYTES   = 40;
   localparam logic [8*58-1:0] B58_SYMBOLS =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } enc_char_type;

   typedef enum int {
      KIND_RANDOM,
      KIND_ZERO,
      KIND_LEAD_ZERO,
      KIND_ONES
   } msg_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;
   logic       rsp_overflow;

   base58_encoder uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .rsp_overflow  (rsp_overflow)
   );

   msg_byte_type  pending_bytes [$];
   enc_char_type  expected_chars [$];
   msg_byte_type  next_item;

   logic [5:0] b58_digits [DIGITS];
   int         zero_run = 0;
   bit         in_zeros = 1'b1;
   int         msg_len = 0;
   bit         dropped = 1'b0;

   int         total_bytes = 0;
   int         items_accepted = 0;
   int         msgs_encoded = 0;
   int         msgs_dropped = 0;
   int         chars_checked = 0;
   int         errors = 0;
   int         cycle_count = 0;
   int         drv_gap = 0;
   int         drv_idle_pct = 0;
   int         mon_gap = 0;
   int         mon_stall_pct = 0;
   logic       hold_active = 1'b0;
   logic       hold_done = 1'b0;
   int         hold_left = 0;
   logic       calm;

   assign calm = (items_accepted + CALM_BYTES >= total_bytes);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_pct();
      int r;
      r = $urandom_range(0, 2);
      return (r == 0) ? 0 : (r == 1) ? 15 : 40;
   endfunction

   task automatic push_byte(input logic [7:0] data, input logic last);
      msg_byte_type item;
      item.data = data;
      item.last = last;
      pending_bytes.push_back(item);
   endtask

   task automatic queue_message(input int len, input msg_kind_type kind);
      int lead;
      logic [7:0] data;
      lead = (kind == KIND_LEAD_ZERO) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
         if (kind == KIND_ZERO || i < lead)
            data = 8'h00;
         else if (kind == KIND_ONES)
            data = 8'hFF;
         else
            data = 8'($urandom_range(0, 255));
         push_byte(data, i == len - 1);
      end
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic lst);
      int carry;
      int top;
      logic [7:0] chars [$];
      enc_char_type e;
      if (msg_len < MAX_BYTES) begin
         msg_len++;
         if (in_zeros && b == 8'h00) begin
            zero_run++;
         end else begin
            in_zeros = 1'b0;
            carry = int'(b);
            for (int i = 0; i < DIGITS; i++) begin
               carry += 256 * int'(b58_digits[i]);
               b58_digits[i] = 6'(carry % RADIX);
               carry /= RADIX;
            end
         end
      end else begin
         dropped = 1'b1;
      end
      if (lst) begin
         for (int k = 0; k < zero_run && chars.size() < MAX_RESULTS; k++)
            chars.push_back(CHAR_ONE);
         top = DIGITS;
         while (top > 0 && b58_digits[top-1] == 6'd0)
            top--;
         while (top > 0 && chars.size() < MAX_RESULTS) begin
            top--;
            chars.push_back(B58_SYMBOLS[8*(57 - int'(b58_digits[top])) +: 8]);
         end
         foreach (chars[k]) begin
            e.ch   = chars[k];
            e.last = (k == chars.size() - 1);
            e.ovf  = dropped;
            expected_chars.push_back(e);
         end
         msgs_encoded++;
         if (dropped)
            msgs_dropped++;
         for (int i = 0; i < DIGITS; i++)
            b58_digits[i] = 6'd0;
         zero_run = 0;
         in_zeros = 1'b1;
         msg_len  = 0;
         dropped  = 1'b0;
      end
   endtask

   task automatic check_char(input logic [7:0] ch, input logic lst, input logic ovf);
      enc_char_type want;
      if (expected_chars.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("Unexpected character %h (last %b, overflow %b)", ch, lst, ovf);
      end else begin
         want = expected_chars.pop_front();
         chars_checked++;
         if (want.ch !== ch || want.last !== lst || want.ovf !== ovf) begin
            errors++;
            if (errors <= 10)
               $display("Mismatch: expected char %h last %b overflow %b, got %h %b %b",
                        want.ch, want.last, want.ovf, ch, lst, ovf);
         end
      end
   endtask

   // Driver: presents pending bytes and predicts each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_byte(req_data_byte, req_last_byte);
            items_accepted <= items_accepted + 1;
            if (req_last_byte)
               drv_idle_pct = pick_pct();
            if (!calm && $urandom_range(0, 99) < drv_idle_pct)
               drv_gap = $urandom_range(1, 10);
         end
         if (!req_valid || req_ready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               next_item = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_item.data;
               req_last_byte <= next_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted character and applies receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_char(rsp_out_char, rsp_last_char, rsp_overflow);
            if (rsp_last_char)
               mon_stall_pct = pick_pct();
         end
         if (mon_gap == 0 && !calm && $urandom_range(0, 99) < mon_stall_pct / 3)
            mon_gap = $urandom_range(1, 10);
         if (hold_active) begin
            rsp_ready <= 1'b0;
         end else if (mon_gap > 0) begin
            mon_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // A single long receiver hold-off, so that the encoder backs up onto its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_done   <= 1'b0;
         hold_left   <= 0;
      end else if (!hold_done && items_accepted >= 40) begin
         hold_active <= 1'b1;
         hold_done   <= 1'b1;
         hold_left   <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1)
            hold_active <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d characters still expected",
                  cycle_count, expected_chars.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int r;
      int len;
      for (int i = 0; i < DIGITS; i++)
         b58_digits[i] = 6'd0;

      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h01, 1'b1);
      push_byte(8'd57, 1'b1);
      push_byte(8'd58, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h7F, 1'b1);

      queue_message(MAX_BYTES, KIND_ONES);
      queue_message(MAX_BYTES + 2, KIND_RANDOM);
      queue_message(MAX_BYTES, KIND_LEAD_ZERO);
      while (pending_bytes.size() < RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            len = $urandom_range(1, 8);
            queue_message(len, ($urandom_range(0, 3) == 0) ? KIND_LEAD_ZERO : KIND_RANDOM);
         end else if (r < 80) begin
            len = $urandom_range(9, MAX_BYTES);
            queue_message(len, ($urandom_range(0, 3) == 0) ? KIND_LEAD_ZERO : KIND_RANDOM);
         end else if (r < 86) begin
            queue_message(MAX_BYTES, KIND_RANDOM);
         end else if (r < 93) begin
            len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 6);
            queue_message(len, ($urandom_range(0, 3) == 0) ? KIND_LEAD_ZERO : KIND_RANDOM);
         end else begin
            len = $urandom_range(1, 6);
            queue_message(len, KIND_ZERO);
         end
      end
      total_bytes = pending_bytes.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (items_accepted == total_bytes);
      wait (expected_chars.size() == 0);
      repeat (200) @(posedge clock);
      errors += expected_chars.size();

      $display("Encoded %0d messages from %0d bytes, %0d of them with dropped bytes.",
               msgs_encoded, total_bytes, msgs_dropped);
      $display("Checked %0d characters under random gaps and one long receiver hold-off.",
               chars_checked);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/b58enc_pkg.sv
hdl/b58enc_ram.sv
hdl/base58_encoder.sv
tb/tb_base58_encoder.sv
